// ----- rtl/core/ring_buffer_fifo_defines.svh -----
`ifndef RING_BUFFER_FIFO_DEFINES_SVH
`define RING_BUFFER_FIFO_DEFINES_SVH

// implication check on clk, off during reset
`define RBF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold
`define RBF_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/core/rbf_pkg.sv -----
package rbf_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CAP_W      = 5;
  localparam int CNT_W      = CAP_W + 1;
  localparam int OP_W       = 3;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE        = 3'd0,
    OP_WRITE_LOSSY  = 3'd1,
    OP_READ         = 3'd2,
    OP_PEEK         = 3'd3,
    OP_WALK_NEXT    = 3'd4,
    OP_WALK_RESTART = 3'd5,
    OP_CLEAR        = 3'd6
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } rbf_cmd_t;

endpackage

// ----- rtl/core/rbf_if.sv -----
interface rbf_in_if import rbf_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       opcode;
  logic [DATA_WIDTH-1:0] write_data;

  modport source (output valid, output opcode, output write_data, input ready);
  modport sink   (input valid, input opcode, input write_data, output ready);
endinterface

interface rbf_out_if import rbf_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  ok;
  logic [DATA_WIDTH-1:0] read_data;
  logic [CAP_W-1:0]      entry_count;
  logic                  is_full;
  logic                  is_empty;

  modport source (output valid, output ok, output read_data, output entry_count,
                  output is_full, output is_empty, input ready);
  modport sink   (input valid, input ok, input read_data, input entry_count,
                  input is_full, input is_empty, output ready);
endinterface

// ----- rtl/core/rbf_ram.sv -----
module rbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/rbf_ctrl.sv -----
`include "ring_buffer_fifo_defines.svh"

module rbf_ctrl import rbf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output rbf_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.capture   = 1'b0;
    cmd.execute   = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready    = !out_valid_r || out_ready;
        cmd.capture = in_valid && in_ready;
        if (cmd.capture) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.execute   = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  `RBF_ASSERT(a_capture_then_exec, cmd.capture |=> cmd.execute, "request not executed")
  `RBF_NEVER(a_exec_over_result, cmd.execute && out_valid_r, "result overwritten")
  `RBF_ASSERT(a_exec_shows_result, cmd.execute |=> out_valid_r, "result not shown")

endmodule

// ----- rtl/core/rbf_datapath.sv -----
`include "ring_buffer_fifo_defines.svh"

module rbf_datapath import rbf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rbf_cmd_t              cmd,
  input  logic [OP_W-1:0]       in_opcode,
  input  logic [DATA_WIDTH-1:0] in_write_data,
  input  logic                  cfg_we,
  input  logic [CAP_W-1:0]      cfg_wdata,
  output logic                  out_ok,
  output logic [DATA_WIDTH-1:0] out_read_data,
  output logic [CAP_W-1:0]      out_entry_count,
  output logic                  out_is_full,
  output logic                  out_is_empty
);

  logic [PTR_W-1:0]      rp_r, rp_nxt, wp_r, wp_nxt, walk_r, walk_nxt;
  logic                  full_r, full_nxt, empty_r, empty_nxt, wstart_r, wstart_nxt;
  logic [CAP_W-1:0]      cap_r, eff_cap;
  op_t                   op_r;
  logic [DATA_WIDTH-1:0] wdata_r;
  logic                  ok_r, ok_nxt;
  logic [DATA_WIDTH-1:0] rdata_r, rdata_nxt;
  logic [CAP_W-1:0]      count_r, count_nxt;
  logic                  ofull_r, oempty_r;
  logic                  ram_we;
  logic [PTR_W-1:0]      ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [CNT_W-1:0]      diff;

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                           input logic [CAP_W-1:0] cap);
    logic [CNT_W-1:0] q;
    q = CNT_W'(p) + CNT_W'(1);
    if (q >= CNT_W'(cap)) begin
      return '0;
    end
    return q[PTR_W-1:0];
  endfunction

  assign ram_raddr = (op_t'(in_opcode) == OP_WALK_NEXT) ? walk_r : rp_r;

  rbf_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_r),
    .wdata(wdata_r),
    .re   (cmd.capture),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CAP_W'(1);
    end else if (cap_r > CAP_W'(DEPTH)) begin
      eff_cap = CAP_W'(DEPTH);
    end else begin
      eff_cap = cap_r;
    end
  end

  always_comb begin
    rp_nxt     = rp_r;
    wp_nxt     = wp_r;
    walk_nxt   = walk_r;
    full_nxt   = full_r;
    empty_nxt  = empty_r;
    wstart_nxt = wstart_r;
    ok_nxt     = 1'b0;
    rdata_nxt  = '0;
    ram_we     = 1'b0;
    case (op_r)
      OP_WRITE: begin
        if (!full_r) begin
          ram_we    = cmd.execute;
          wp_nxt    = adv(wp_r, eff_cap);
          empty_nxt = 1'b0;
          full_nxt  = (wp_nxt == rp_r);
          ok_nxt    = 1'b1;
        end
      end
      OP_WRITE_LOSSY: begin
        if (full_r) begin
          rp_nxt = adv(rp_r, eff_cap);
        end
        ram_we    = cmd.execute;
        wp_nxt    = adv(wp_r, eff_cap);
        empty_nxt = 1'b0;
        full_nxt  = (wp_nxt == rp_nxt);
        ok_nxt    = 1'b1;
      end
      OP_READ, OP_PEEK: begin
        if (!empty_r) begin
          rdata_nxt = ram_rdata;
          ok_nxt    = 1'b1;
          if (op_r == OP_READ) begin
            rp_nxt    = adv(rp_r, eff_cap);
            full_nxt  = 1'b0;
            empty_nxt = (rp_nxt == wp_r);
          end
        end
      end
      OP_WALK_NEXT: begin
        if (!empty_r && (wstart_r || walk_r != wp_r)) begin
          rdata_nxt  = ram_rdata;
          wstart_nxt = 1'b0;
          walk_nxt   = adv(walk_r, eff_cap);
          ok_nxt     = 1'b1;
        end
      end
      OP_WALK_RESTART: begin
        walk_nxt   = rp_r;
        wstart_nxt = 1'b1;
        ok_nxt     = 1'b1;
      end
      OP_CLEAR: begin
        rp_nxt    = '0;
        wp_nxt    = '0;
        full_nxt  = 1'b0;
        empty_nxt = 1'b1;
        ok_nxt    = 1'b1;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // entries held, wrapped span clamped to the effective capacity
  always_comb begin
    if (wp_nxt >= rp_nxt) begin
      diff = CNT_W'(wp_nxt) - CNT_W'(rp_nxt);
    end else begin
      diff = CNT_W'(eff_cap) - CNT_W'(rp_nxt) + CNT_W'(wp_nxt);
    end
    if (empty_nxt) begin
      count_nxt = '0;
    end else if (full_nxt) begin
      count_nxt = eff_cap;
    end else if (diff[CNT_W-1]) begin
      count_nxt = '0;
    end else if (diff[CAP_W-1:0] > eff_cap) begin
      count_nxt = eff_cap;
    end else begin
      count_nxt = diff[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r     <= '0;
      wp_r     <= '0;
      walk_r   <= '0;
      full_r   <= 1'b0;
      empty_r  <= 1'b1;
      wstart_r <= 1'b1;
      cap_r    <= CAP_W'(DEPTH);
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cmd.execute) begin
        rp_r     <= rp_nxt;
        wp_r     <= wp_nxt;
        walk_r   <= walk_nxt;
        full_r   <= full_nxt;
        empty_r  <= empty_nxt;
        wstart_r <= wstart_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= op_t'(in_opcode);
      wdata_r <= in_write_data;
    end
    if (cmd.execute) begin
      ok_r     <= ok_nxt;
      rdata_r  <= rdata_nxt;
      count_r  <= count_nxt;
      ofull_r  <= full_nxt;
      oempty_r <= empty_nxt;
    end
  end

  assign out_ok          = ok_r;
  assign out_read_data   = rdata_r;
  assign out_entry_count = count_r;
  assign out_is_full     = ofull_r;
  assign out_is_empty    = oempty_r;

  `RBF_NEVER(a_full_and_empty, full_r && empty_r, "full and empty together")
  `RBF_ASSERT(a_clear_empties, cmd.execute && op_r == OP_CLEAR |=> empty_r && !full_r,
              "clear left entries")
  `RBF_ASSERT(a_state_holds, !cmd.execute |=> $stable(rp_r) && $stable(wp_r),
              "pointer moved without request")

endmodule

// ----- rtl/core/ring_buffer_fifo.sv -----
// Ring buffer FIFO with walk cursor.
// A captured request executes in the EXEC state; the result and out_valid are then registered.
// The controller takes no new request while it executes the last one (EXEC state).
// A pending result does not block the next accept once it is taken that cycle.
// Reset (rst_n, sync, active low): empty, pointers zero, capacity 16, RAM undefined.
module ring_buffer_fifo import rbf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  rbf_in_if.sink           in_ch,
  rbf_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  rbf_cmd_t cmd;

  rbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cmd      (cmd)
  );

  rbf_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_opcode      (in_ch.opcode),
    .in_write_data  (in_ch.write_data),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_ok         (out_ch.ok),
    .out_read_data  (out_ch.read_data),
    .out_entry_count(out_ch.entry_count),
    .out_is_full    (out_ch.is_full),
    .out_is_empty   (out_ch.is_empty)
  );

endmodule
